// ----- rtl/core/mse_pkg.sv -----
// Shared types, constants and helpers of the Mandelbrot smooth escape core.
`timescale 1ns / 1ps
package mse_pkg;

   localparam logic [2:0] CSR_CENTER_X     = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y     = 3'd1;
   localparam logic [2:0] CSR_STEP_SIZE    = 3'd2;
   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd4;

   localparam logic [63:0] FOUR_Q56   = 64'h0400_0000_0000_0000;
   localparam logic [21:0] LOG_OFF_56 = 22'(56 << 16);
   localparam logic [21:0] LOG_OFF_16 = 22'(16 << 16);

   typedef struct packed {
      logic signed [31:0] cr;
      logic signed [31:0] ci;
   } point_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_MUL,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_ADD,
      BACK_NORM,
      BACK_SQ,
      BACK_SQF,
      BACK_FIX,
      BACK_DIV,
      BACK_OUT
   } back_state_type;

   function automatic logic signed [31:0] sat_q428(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sh0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -48'sh0000_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/mse_front.sv -----
// Front end: accepts a pixel beat and maps it to the point c on the complex plane.
`timescale 1ns / 1ps
module mse_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [11:0]             req_pixel_x,
   input  logic [11:0]             req_pixel_y,
   input  logic signed [31:0]      center_x,
   input  logic signed [31:0]      center_y,
   input  logic [30:0]             step_size,
   input  logic [12:0]             image_width,
   input  logic [12:0]             image_height,
   input  mse_pkg::fifo_status_type fifo_status,
   output logic                    push,
   output mse_pkg::point_type      push_point
);

   mse_pkg::front_state_type state_ff, state_in;
   logic [11:0]        px_ff, px_in, py_ff, py_in;
   logic signed [44:0] prx_ff, prx_in, pry_ff, pry_in;
   logic signed [13:0] dx, dy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mse_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      px_ff  <= px_in;
      py_ff  <= py_in;
      prx_ff <= prx_in;
      pry_ff <= pry_in;
   end

   always_comb begin
      state_in  = state_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      prx_in    = prx_ff;
      pry_in    = pry_ff;
      push      = 1'b0;
      req_stall = (state_ff != mse_pkg::FRONT_IDLE);
      dx = $signed({2'b00, px_ff}) - $signed({2'b00, image_width[12:1]});
      dy = $signed({2'b00, py_ff}) - $signed({2'b00, image_height[12:1]});
      push_point.cr = mse_pkg::sat_q428(48'(center_x) + 48'(prx_ff));
      push_point.ci = mse_pkg::sat_q428(48'(center_y) + 48'(pry_ff));
      unique case (state_ff)
         mse_pkg::FRONT_IDLE: begin
            if (req_valid) begin
               px_in    = req_pixel_x;
               py_in    = req_pixel_y;
               state_in = mse_pkg::FRONT_MUL;
            end
         end
         mse_pkg::FRONT_MUL: begin
            prx_in   = 45'($signed({1'b0, step_size})) * 45'(dx);
            pry_in   = 45'($signed({1'b0, step_size})) * 45'(dy);
            state_in = mse_pkg::FRONT_PUSH;
         end
         mse_pkg::FRONT_PUSH: begin
            if (!fifo_status.full) begin
               push     = 1'b1;
               state_in = mse_pkg::FRONT_IDLE;
            end
         end
         default: state_in = mse_pkg::FRONT_IDLE;
      endcase
   end

endmodule

// ----- rtl/core/mse_fifo.sv -----
// Two-entry queue of mapped points between the front end and the iteration engine.
`timescale 1ns / 1ps
module mse_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mse_pkg::point_type       push_point,
   input  logic                     pop,
   output mse_pkg::point_type       pop_point,
   output mse_pkg::fifo_status_type status
);

   mse_pkg::point_type entry_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ff] <= push_point;
      end
   end

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
      pop_point    = entry_ff[rd_ff];
      status.full  = (count_ff == 2'd2);
      status.empty = (count_ff == 2'd0);
   end

endmodule

// ----- rtl/core/mse_back.sv -----
// Iteration engine: escape loop, two-pass logarithm and the final normalising division.
`timescale 1ns / 1ps
module mse_back #(
   parameter int MAX_ITER = 512
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mse_pkg::fifo_status_type fifo_status,
   input  mse_pkg::point_type       pop_point,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_escaped,
   output logic [9:0]               rsp_iteration_count,
   output logic [16:0]              rsp_smooth_value
);

   localparam int JW    = $clog2(MAX_ITER + 1);
   localparam int CW    = (JW > 10) ? JW : 10;
   localparam int NUM_W = JW + 16;
   localparam int RS    = NUM_W + $clog2(MAX_ITER);
   localparam logic [NUM_W:0] RECIP =
      (NUM_W + 1)'(((64'd1 << RS) + 64'(MAX_ITER) - 64'd1) / 64'(MAX_ITER));

   mse_pkg::back_state_type state_ff, state_in;
   logic signed [31:0] cr_ff, cr_in, ci_ff, ci_in, zr_ff, zr_in, zi_ff, zi_in;
   logic signed [63:0] rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [JW-1:0]      j_ff, j_in;
   logic               esc_ff, esc_in, pass_ff, pass_in;
   logic [63:0]        lv_ff, lv_in;
   logic [5:0]         nc_ff, nc_in, e_ff, e_in;
   logic [30:0]        x_ff, x_in;
   logic [61:0]        prod_ff, prod_in;
   logic [15:0]        f_ff, f_in;
   logic [3:0]         k_ff, k_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;

   logic [63:0]        mag;
   logic signed [63:0] diff;
   logic [31:0]        t;
   logic [21:0]        lval, aval, nu;
   logic [NUM_W-1:0]   num;
   logic [2*NUM_W:0]   qprod;
   logic [CW-1:0]      jx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mse_pkg::BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cr_ff   <= cr_in;
      ci_ff   <= ci_in;
      zr_ff   <= zr_in;
      zi_ff   <= zi_in;
      rr_ff   <= rr_in;
      ii_ff   <= ii_in;
      ri_ff   <= ri_in;
      j_ff    <= j_in;
      esc_ff  <= esc_in;
      pass_ff <= pass_in;
      lv_ff   <= lv_in;
      nc_ff   <= nc_in;
      e_ff    <= e_in;
      x_ff    <= x_in;
      prod_ff <= prod_in;
      f_ff    <= f_in;
      k_ff    <= k_in;
      quo_ff  <= quo_in;
   end

   always_comb begin
      state_in = state_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      rr_in    = rr_ff;
      ii_in    = ii_ff;
      ri_in    = ri_ff;
      j_in     = j_ff;
      esc_in   = esc_ff;
      pass_in  = pass_ff;
      lv_in    = lv_ff;
      nc_in    = nc_ff;
      e_in     = e_ff;
      x_in     = x_ff;
      prod_in  = prod_ff;
      f_in     = f_ff;
      k_in     = k_ff;
      quo_in   = quo_ff;
      pop      = 1'b0;

      mag   = rr_ff + ii_ff;
      diff  = rr_ff - ii_ff;
      t     = 32'(prod_ff >> 30);
      lval  = {e_ff, f_ff};
      aval  = (lval > mse_pkg::LOG_OFF_56) ? ((lval - mse_pkg::LOG_OFF_56) >> 1) : 22'd0;
      nu    = (lval > mse_pkg::LOG_OFF_16) ? (lval - mse_pkg::LOG_OFF_16) : 22'd0;
      num   = {j_ff + JW'(1), 16'd0};
      qprod = (2*NUM_W + 1)'(quo_ff) * (2*NUM_W + 1)'(RECIP);

      unique case (state_ff)
         mse_pkg::BACK_IDLE: begin
            if (!fifo_status.empty) begin
               pop      = 1'b1;
               cr_in    = pop_point.cr;
               ci_in    = pop_point.ci;
               zr_in    = 32'sd0;
               zi_in    = 32'sd0;
               j_in     = '0;
               state_in = mse_pkg::BACK_MUL;
            end
         end
         mse_pkg::BACK_MUL: begin
            rr_in    = 64'(zr_ff) * 64'(zr_ff);
            ii_in    = 64'(zi_ff) * 64'(zi_ff);
            ri_in    = 64'(zr_ff) * 64'(zi_ff);
            state_in = mse_pkg::BACK_ADD;
         end
         mse_pkg::BACK_ADD: begin
            if (mag >= mse_pkg::FOUR_Q56) begin
               esc_in   = 1'b1;
               lv_in    = mag;
               nc_in    = 6'd0;
               f_in     = 16'd0;
               k_in     = 4'd0;
               pass_in  = 1'b0;
               state_in = mse_pkg::BACK_NORM;
            end else begin
               zr_in = mse_pkg::sat_q428(48'(diff >>> 28) + 48'(cr_ff));
               zi_in = mse_pkg::sat_q428(48'(ri_ff >>> 27) + 48'(ci_ff));
               j_in  = j_ff + JW'(1);
               if (j_ff + JW'(1) == JW'(MAX_ITER)) begin
                  esc_in   = 1'b0;
                  quo_in   = '0;
                  state_in = mse_pkg::BACK_OUT;
               end else begin
                  state_in = mse_pkg::BACK_MUL;
               end
            end
         end
         mse_pkg::BACK_NORM: begin
            if (lv_ff == 64'd0) begin
               e_in     = 6'd0;
               f_in     = 16'd0;
               state_in = mse_pkg::BACK_FIX;
            end else if (lv_ff[63]) begin
               x_in     = lv_ff[63:33];
               e_in     = 6'd63 - nc_ff;
               state_in = mse_pkg::BACK_SQ;
            end else begin
               lv_in = lv_ff << 1;
               nc_in = nc_ff + 6'd1;
            end
         end
         mse_pkg::BACK_SQ: begin
            prod_in  = 62'(x_ff) * 62'(x_ff);
            state_in = mse_pkg::BACK_SQF;
         end
         mse_pkg::BACK_SQF: begin
            f_in = {f_ff[14:0], t[31]};
            x_in = t[31] ? t[31:1] : t[30:0];
            k_in = k_ff + 4'd1;
            state_in = (k_ff == 4'd15) ? mse_pkg::BACK_FIX : mse_pkg::BACK_SQ;
         end
         mse_pkg::BACK_FIX: begin
            if (!pass_ff) begin
               lv_in    = 64'(aval);
               nc_in    = 6'd0;
               f_in     = 16'd0;
               k_in     = 4'd0;
               pass_in  = 1'b1;
               state_in = mse_pkg::BACK_NORM;
            end else begin
               quo_in   = (32'(num) > 32'(nu)) ? (num - NUM_W'(nu)) : '0;
               state_in = mse_pkg::BACK_DIV;
            end
         end
         mse_pkg::BACK_DIV: begin
            // Division by the iteration limit as a multiplication by its rounded-up
            // reciprocal, exact for every numerator that fits in NUM_W bits.
            quo_in   = NUM_W'(qprod >> RS);
            state_in = mse_pkg::BACK_OUT;
         end
         mse_pkg::BACK_OUT: begin
            if (!rsp_stall) begin
               state_in = mse_pkg::BACK_IDLE;
            end
         end
         default: state_in = mse_pkg::BACK_IDLE;
      endcase

      jx                  = CW'(j_ff);
      rsp_valid           = (state_ff == mse_pkg::BACK_OUT);
      rsp_escaped         = esc_ff;
      rsp_iteration_count = (jx > CW'(1023)) ? 10'd1023 : jx[9:0];
      rsp_smooth_value    = quo_ff[16:0];
   end

endmodule

// ----- rtl/core/mandelbrot_smooth_escape_core.sv -----
// Top level of the Mandelbrot smooth escape core: registers, front end, queue and engine.
// A beat passes the front end's capture, multiply and push states, then the engine's
// multiply and add states once per iteration (at most MAX_ITER iterations), and on escape
// two logarithm passes of normalising shifts and squaring steps, then the reciprocal divide.
// The engine handles one point at a time and pops the next once its result is taken; it
// sets the rate. Reset is synchronous; it clears all control state and sets the registers.
`timescale 1ns / 1ps
module mandelbrot_smooth_escape_core #(
   parameter int MAX_ITER = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_pixel_x,
   input  logic [11:0] req_pixel_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_escaped,
   output logic [9:0]  rsp_iteration_count,
   output logic [16:0] rsp_smooth_value,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   logic signed [31:0] center_x_ff, center_y_ff;
   logic [30:0]        step_size_ff;
   logic [12:0]        image_width_ff, image_height_ff;

   logic                     push, pop;
   mse_pkg::point_type       push_point, pop_point;
   mse_pkg::fifo_status_type fifo_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= 32'sd0;
         center_y_ff     <= 32'sd0;
         step_size_ff    <= 31'd2097152;
         image_width_ff  <= 13'd1024;
         image_height_ff <= 13'd1024;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mse_pkg::CSR_CENTER_X:     center_x_ff     <= csr_write_data;
            mse_pkg::CSR_CENTER_Y:     center_y_ff     <= csr_write_data;
            mse_pkg::CSR_STEP_SIZE:    step_size_ff    <= csr_write_data[30:0];
            mse_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data[12:0];
            mse_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data[12:0];
            default: ;
         endcase
      end
   end

   mse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pixel_x  (req_pixel_x),
      .req_pixel_y  (req_pixel_y),
      .center_x     (center_x_ff),
      .center_y     (center_y_ff),
      .step_size    (step_size_ff),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .fifo_status  (fifo_status),
      .push         (push),
      .push_point   (push_point)
   );

   mse_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_point (push_point),
      .pop        (pop),
      .pop_point  (pop_point),
      .status     (fifo_status)
   );

   mse_back #(
      .MAX_ITER (MAX_ITER)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .fifo_status         (fifo_status),
      .pop_point           (pop_point),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_escaped         (rsp_escaped),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_smooth_value    (rsp_smooth_value)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_status.full)
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_status.empty)
      else $error("queue read while empty");

   a_smooth_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_escaped) |-> (rsp_smooth_value == 17'd0))
      else $error("smooth value set on a point that did not escape");

   a_escape_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_escaped) |-> (32'(rsp_iteration_count) < 32'(MAX_ITER)))
      else $error("escaped beat carries the iteration limit");

endmodule
